// File: hw/rtl/scw_pkg.sv
// Package for the scan curvature window block.
// Holds field widths, window geometry, payload types and reset constants.
// No dependencies; imported by scan_curvature_window and scw_checker.
package scw_pkg;

    // Field widths
    localparam int COORD_W = 20;
    localparam int SUM_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int CURV_W  = 49;
    localparam int IDX_W   = 19;
    localparam int THR_W   = 30;

    // Window geometry
    localparam int HALF_WINDOW = 5;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
    localparam int FILL_W      = 4;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_X      = 0;
    localparam int AXIS_Y      = 1;
    localparam int AXIS_Z      = 2;

    // Defaults
    localparam int MAX_FRAME_POINTS_DEF = 524288;
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(100000);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic [SQ_W-1:0]           t_sq;
    typedef logic [CURV_W-1:0]         t_curv;
    typedef logic [IDX_W-1:0]          t_index;
    typedef logic [THR_W-1:0]          t_thresh;
    typedef logic [FILL_W-1:0]         t_fill;

endpackage

// File: hw/rtl/scan_curvature_window.sv
// Streaming 11-point curvature of lidar scan points.
// Depends on scw_pkg for widths, types and constants.
//
// Usage: points enter on the input channel (i_in_valid / o_in_ready) as signed
// millimetre x, y, z with a frame end mark. Each point shifts into an 11-tap
// window. Once 11 points of the current frame are in, every new point yields
// one result on the output channel (o_out_valid / i_out_ready) for the point
// five places back: squared norm of neighbour sum minus ten times the centre,
// its frame index, and sharp/flat flags against the edge threshold register.
// The first and last five points of a frame give no result.
// The threshold is written through i_cfg_valid / o_cfg_ready, which is always
// ready; write it only while the block is idle.
// A result passes through the window, sum, difference, square and output
// registers after the beat of the point that completes it. Throughput: one
// point per cycle while results are taken, set by the five-stage pipeline.
// Each stage advances when the stage after it is empty or moving, so while the
// receiver stalls the block still takes points until every stage holds one.
// Reset (synchronous, active low) zeroes the window fill count, empties the
// pipeline, zeroes the frame position and loads the threshold with 100000.
module scan_curvature_window #(
    parameter int MAX_FRAME_POINTS = scw_pkg::MAX_FRAME_POINTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Point channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  scw_pkg::t_coord        i_pos_x,
    input  scw_pkg::t_coord        i_pos_y,
    input  scw_pkg::t_coord        i_pos_z,
    input  logic                   i_frame_end,
    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output scw_pkg::t_curv         o_curvature,
    output scw_pkg::t_index        o_point_index,
    output logic                   o_is_sharp,
    output logic                   o_is_flat,
    // Configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  scw_pkg::t_thresh       i_edge_threshold
);
    import scw_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_POINTS);

    // Window and frame state
    t_coord             r_win [NUM_AXES][WIN_LEN];
    t_fill              r_fill;
    logic [POS_W-1:0]   r_pos;
    t_thresh            r_thresh;

    // Pipeline registers
    logic               r_a_vld;
    t_index             r_a_idx;
    logic               r_b_vld;
    t_index             r_b_idx;
    t_sum               r_b_lo  [NUM_AXES];
    t_sum               r_b_hi  [NUM_AXES];
    t_sum               r_b_c10 [NUM_AXES];
    logic               r_c_vld;
    t_index             r_c_idx;
    t_mag               r_c_mag [NUM_AXES];
    logic               r_d_vld;
    t_index             r_d_idx;
    t_sq                r_d_sq  [NUM_AXES];
    logic               r_out_vld;
    t_curv              r_curv;
    t_index             r_out_idx;
    logic               r_sharp;
    logic               r_flat;

    // Stage enables and handshake
    logic               w_en_out;
    logic               w_en_d;
    logic               w_en_c;
    logic               w_en_b;
    logic               w_en_a;
    logic               w_accept;
    logic               w_full_next;
    t_fill              n_fill;
    logic [POS_W-1:0]   n_pos;
    logic [POS_W-1:0]   w_idx;
    logic [POS_W:0]     w_wrap;
    logic [IDX_W+POS_W-1:0] w_idx_ext;
    t_coord             w_new [NUM_AXES];
    t_sum               n_lo  [NUM_AXES];
    t_sum               n_hi  [NUM_AXES];
    t_sum               n_c10 [NUM_AXES];
    t_mag               n_mag [NUM_AXES];
    t_sq                n_sq  [NUM_AXES];
    t_curv              n_curv;
    logic [CURV_W+1:0]  w_curv_sum;

    // A stage moves when the one after it is empty or moving.
    assign w_en_out   = !r_out_vld || i_out_ready;
    assign w_en_d     = !r_d_vld || w_en_out;
    assign w_en_c     = !r_c_vld || w_en_d;
    assign w_en_b     = !r_b_vld || w_en_c;
    assign w_en_a     = !r_a_vld || w_en_b;
    assign o_in_ready = w_en_a;
    assign w_accept   = i_in_valid && w_en_a;
    assign o_cfg_ready = 1'b1;

    assign w_new[AXIS_X] = i_pos_x;
    assign w_new[AXIS_Y] = i_pos_y;
    assign w_new[AXIS_Z] = i_pos_z;

    // Fill count, frame position and index of the centre point.
    always_comb begin
        w_full_next = (r_fill >= FILL_W'(WIN_LEN - 1));
        if (i_frame_end) begin
            n_fill = '0;
        end else if (r_fill < FILL_W'(WIN_LEN)) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
        if (i_frame_end || (r_pos == POS_W'(MAX_FRAME_POINTS - 1))) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
        w_wrap = {1'b0, r_pos} + (POS_W + 1)'(MAX_FRAME_POINTS - HALF_WINDOW);
        if (r_pos >= POS_W'(HALF_WINDOW)) begin
            w_idx = r_pos - POS_W'(HALF_WINDOW);
        end else begin
            w_idx = w_wrap[POS_W-1:0];
        end
        w_idx_ext = {{IDX_W{1'b0}}, w_idx};
    end

    // Window shift and frame state; the window is never cleared, since a
    // result needs eleven fresh points after a frame end anyway.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    r_win[ax][i] <= r_win[ax][i+1];
                end
                r_win[ax][WIN_LEN-1] <= w_new[ax];
            end
            r_a_idx <= w_idx_ext[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_pos    <= '0;
            r_a_vld  <= 1'b0;
            r_thresh <= THRESH_RESET;
        end else begin
            if (w_accept) begin
                r_fill <= n_fill;
                r_pos  <= n_pos;
            end
            if (w_en_a) begin
                r_a_vld <= w_accept && w_full_next;
            end
            if (i_cfg_valid) begin
                r_thresh <= i_edge_threshold;
            end
        end
    end

    // Partial neighbour sums and ten times the centre.
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            n_lo[ax] = '0;
            n_hi[ax] = '0;
            for (int i = 0; i < HALF_WINDOW; i++) begin
                n_lo[ax] = n_lo[ax] + SUM_W'(r_win[ax][i]);
                n_hi[ax] = n_hi[ax] + SUM_W'(r_win[ax][HALF_WINDOW + 1 + i]);
            end
            n_c10[ax] = (SUM_W'(r_win[ax][HALF_WINDOW]) <<< 3)
                      + (SUM_W'(r_win[ax][HALF_WINDOW]) <<< 1);
        end
    end

    // Magnitude of the difference per axis.
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            t_diff d;
            d = DIFF_W'(r_b_lo[ax]) + DIFF_W'(r_b_hi[ax]) - DIFF_W'(r_b_c10[ax]);
            if (d[DIFF_W-1]) begin
                d = -d;
            end
            n_mag[ax] = d[MAG_W-1:0];
        end
    end

    // One square per axis.
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            n_sq[ax] = SQ_W'(r_c_mag[ax]) * SQ_W'(r_c_mag[ax]);
        end
    end

    // Curvature sum.
    assign w_curv_sum = (CURV_W + 2)'(r_d_sq[AXIS_X]) + (CURV_W + 2)'(r_d_sq[AXIS_Y])
                      + (CURV_W + 2)'(r_d_sq[AXIS_Z]);
    assign n_curv = w_curv_sum[CURV_W-1:0];

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_idx <= r_a_idx;
            r_b_lo  <= n_lo;
            r_b_hi  <= n_hi;
            r_b_c10 <= n_c10;
        end
        if (w_en_c) begin
            r_c_idx <= r_b_idx;
            r_c_mag <= n_mag;
        end
        if (w_en_d) begin
            r_d_idx <= r_c_idx;
            r_d_sq  <= n_sq;
        end
        if (w_en_out) begin
            r_out_idx <= r_d_idx;
            r_curv    <= n_curv;
            r_sharp   <= (n_curv > CURV_W'(r_thresh));
            r_flat    <= (n_curv < CURV_W'(r_thresh));
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_en_c) begin
                r_c_vld <= r_b_vld;
            end
            if (w_en_d) begin
                r_d_vld <= r_c_vld;
            end
            if (w_en_out) begin
                r_out_vld <= r_d_vld;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_curvature   = r_curv;
    assign o_point_index = r_out_idx;
    assign o_is_sharp    = r_sharp;
    assign o_is_flat     = r_flat;

endmodule

// File: hw/rtl/scw_checker.sv
// Port-level checker for scan_curvature_window, attached by bind.
// Depends on scw_pkg for field types and widths.
module scw_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  scw_pkg::t_curv         o_curvature,
    input  scw_pkg::t_index        o_point_index,
    input  logic                   o_is_sharp,
    input  logic                   o_is_flat
);
    import scw_pkg::*;

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_curvature) && $stable(o_point_index)
            && $stable(o_is_sharp) && $stable(o_is_flat))
        else $error("result payload changed while stalled");

    // Sharp and flat are exclusive.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_sharp && o_is_flat))
        else $error("point flagged both sharp and flat");

    // A sharp point lies above a non-negative threshold, so it is never zero.
    a_sharp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_sharp |-> o_curvature != '0)
        else $error("sharp point with zero curvature");

    // A flat point lies below a 30-bit threshold.
    a_flat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_flat |-> (o_curvature >> THR_W) == '0)
        else $error("flat point above threshold range");

endmodule

bind scan_curvature_window scw_checker u_scw_checker (.*);
